// File: design/gcrf_pkg.sv
// shared types, constants, disk-code tables and the sequencer microprogram
package gcrf_pkg;

	// track geometry
	localparam int TRACK_SIZE_DEF = 6656;
	localparam int FMT_BYTES = 6240;
	localparam int ADDR_W = 12;
	localparam int CFG_IDX_W = 1;

	// byte offsets inside one 390-byte sector span
	localparam logic [8:0] OFF_AMARK = 9'd21;
	localparam logic [8:0] OFF_AFIELD = 9'd24;
	localparam logic [8:0] OFF_ATAIL = 9'd32;
	localparam logic [8:0] OFF_GAP = 9'd35;
	localparam logic [8:0] OFF_DMARK = 9'd41;
	localparam logic [8:0] OFF_DATA = 9'd44;
	localparam logic [8:0] OFF_UPPER = 9'd130;
	localparam logic [8:0] OFF_CSUM = 9'd386;
	localparam logic [8:0] OFF_DTAIL = 9'd387;
	localparam logic [8:0] OFF_END = 9'd389;

	// auxiliary groups
	localparam logic [8:0] AUX_TOP = 9'd129;
	localparam logic [7:0] AUX_STRIDE = 8'd86;
	localparam logic [7:0] AUX_STRIDE2 = 8'd172;
	localparam logic [6:0] AUX_FULL = 7'd84;

	localparam logic [7:0] VOLUME = 8'd254;
	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] ODD_EVEN_MASK = 8'hAA;

	localparam logic [7:0] ADDR_MARK [3] = '{8'hD5, 8'hAA, 8'h96};
	localparam logic [7:0] DATA_MARK [3] = '{8'hD5, 8'hAA, 8'hAD};
	localparam logic [7:0] TAIL_MARK [3] = '{8'hDE, 8'hAA, 8'hEB};

	localparam logic [7:0] DISK_CODE [64] = '{
		8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
		8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
		8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
		8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
		8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
		8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
		8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
		8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
	};

	// physical to logical sector interleave
	localparam logic [3:0] ORDER_DOS [16] = '{
		4'd0, 4'd7, 4'd14, 4'd6, 4'd13, 4'd5, 4'd12, 4'd4,
		4'd11, 4'd3, 4'd10, 4'd2, 4'd9, 4'd1, 4'd8, 4'd15
	};
	localparam logic [3:0] ORDER_PRO [16] = '{
		4'd0, 4'd8, 4'd1, 4'd9, 4'd2, 4'd10, 4'd3, 4'd11,
		4'd4, 4'd12, 4'd5, 4'd13, 4'd6, 4'd14, 4'd7, 4'd15
	};

	// input opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PULL = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRACK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'b1;

	// byte class seen by the sequencer dispatch
	localparam logic [1:0] CLS_CONST = 2'd0;
	localparam logic [1:0] CLS_AUX = 2'd1;
	localparam logic [1:0] CLS_UP = 2'd2;

	// read address selects
	localparam logic [1:0] RD_A = 2'd0;
	localparam logic [1:0] RD_B = 2'd1;
	localparam logic [1:0] RD_C = 2'd2;
	localparam logic [1:0] RD_U = 2'd3;

	// accumulator capture ops
	localparam logic [2:0] CAP_NONE = 3'd0;
	localparam logic [2:0] CAP_LO = 3'd1;
	localparam logic [2:0] CAP_MID = 3'd2;
	localparam logic [2:0] CAP_HI = 3'd3;
	localparam logic [2:0] CAP_UP = 3'd4;

	// jump kinds
	localparam logic [1:0] J_NEXT = 2'd0;
	localparam logic [1:0] J_WAIT = 2'd1;
	localparam logic [1:0] J_CLASS = 2'd2;
	localparam logic [1:0] J_EMIT = 2'd3;

	// program steps
	localparam logic [3:0] P_IDLE = 4'd0;
	localparam logic [3:0] P_CLASS = 4'd1;
	localparam logic [3:0] P_AUX_A = 4'd2;
	localparam logic [3:0] P_AUX_B = 4'd3;
	localparam logic [3:0] P_AUX_C = 4'd4;
	localparam logic [3:0] P_AUX_D = 4'd5;
	localparam logic [3:0] P_UP_A = 4'd6;
	localparam logic [3:0] P_UP_B = 4'd7;
	localparam logic [3:0] P_EMIT_D = 4'd8;
	localparam logic [3:0] P_EMIT_C = 4'd9;

	typedef struct packed {
		logic opcode;
		logic [11:0] load_address;
		logic [7:0] load_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] track_byte;
		logic last_byte;
	} out_item_t;

	// datapath control word
	typedef struct packed {
		logic rd_en;
		logic [1:0] rd_sel;
		logic [2:0] cap;
		logic emit;
		logic emit_data;
	} ctrl_t;

	typedef struct packed {
		logic [1:0] jmp;
		logic [3:0] next;
		ctrl_t ctrl;
	} uword_t;

	// microprogram rom
	function automatic uword_t ucode(input logic [3:0] pc);
		uword_t uw;
		uw = '0;
		case (pc)
			P_IDLE: begin
				uw.jmp = J_WAIT;
				uw.next = P_CLASS;
			end
			P_CLASS: begin
				uw.jmp = J_CLASS;
				uw.next = P_IDLE;
			end
			P_AUX_A: begin
				uw.next = P_AUX_B;
				uw.ctrl.rd_en = 1'b1;
				uw.ctrl.rd_sel = RD_A;
			end
			P_AUX_B: begin
				uw.next = P_AUX_C;
				uw.ctrl.rd_en = 1'b1;
				uw.ctrl.rd_sel = RD_B;
				uw.ctrl.cap = CAP_LO;
			end
			P_AUX_C: begin
				uw.next = P_AUX_D;
				uw.ctrl.rd_en = 1'b1;
				uw.ctrl.rd_sel = RD_C;
				uw.ctrl.cap = CAP_MID;
			end
			P_AUX_D: begin
				uw.next = P_EMIT_D;
				uw.ctrl.cap = CAP_HI;
			end
			P_UP_A: begin
				uw.next = P_UP_B;
				uw.ctrl.rd_en = 1'b1;
				uw.ctrl.rd_sel = RD_U;
			end
			P_UP_B: begin
				uw.next = P_EMIT_D;
				uw.ctrl.cap = CAP_UP;
			end
			P_EMIT_D: begin
				uw.jmp = J_EMIT;
				uw.next = P_IDLE;
				uw.ctrl.emit = 1'b1;
				uw.ctrl.emit_data = 1'b1;
			end
			P_EMIT_C: begin
				uw.jmp = J_EMIT;
				uw.next = P_IDLE;
				uw.ctrl.emit = 1'b1;
			end
			default: begin
				uw.jmp = J_NEXT;
				uw.next = P_IDLE;
			end
		endcase
		return uw;
	endfunction

endpackage

// File: design/gcrf_store.sv
// image byte store, one write and one registered read per cycle
module gcrf_store
	import gcrf_pkg::*;
(
	input logic clk,
	input logic we,
	input logic [ADDR_W-1:0] waddr,
	input logic [7:0] wdata,
	input logic re,
	input logic [ADDR_W-1:0] raddr,
	output logic [7:0] rdata
);

	logic [7:0] mem [2**ADDR_W];

	// write on load, registered read for the datapath
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/gcrf_seq.sv
// step counter and microprogram sequencer
module gcrf_seq
	import gcrf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic pull,
	input logic [1:0] cls,
	input logic out_busy,
	output ctrl_t ctrl,
	output logic idle
);

	logic [3:0] pc_q;
	logic [3:0] pc_d;
	uword_t uw;

	assign uw = ucode(pc_q);
	assign idle = (pc_q == P_IDLE);

	// emit only when the output register can take the item
	always_comb begin
		ctrl = uw.ctrl;
		ctrl.emit = uw.ctrl.emit & ~out_busy;
	end

	// next step selection
	always_comb begin
		pc_d = uw.next;
		case (uw.jmp)
			J_NEXT: pc_d = uw.next;
			J_WAIT: pc_d = pull ? uw.next : pc_q;
			J_CLASS: begin
				case (cls)
					CLS_AUX: pc_d = P_AUX_A;
					CLS_UP: pc_d = P_UP_A;
					default: pc_d = P_EMIT_C;
				endcase
			end
			J_EMIT: pc_d = out_busy ? pc_q : uw.next;
			default: pc_d = P_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= P_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// File: design/gcrf_dp.sv
// track position, store addressing, 6-and-2 chain and byte formation
module gcrf_dp
	import gcrf_pkg::*;
#(
	parameter int TRACK_SIZE = TRACK_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	input ctrl_t ctrl,
	input logic [7:0] trk_num,
	input logic sector_order,
	input logic [7:0] rdata,
	output logic re,
	output logic [ADDR_W-1:0] raddr,
	output logic [1:0] cls,
	output logic [7:0] byte_out,
	output logic last_out
);

	localparam int POS_W = $clog2(TRACK_SIZE);
	localparam logic [POS_W:0] TRACK_LIM = (POS_W+1)'(TRACK_SIZE);
	localparam logic [POS_W:0] FMT_LIM = (POS_W+1)'(FMT_BYTES);

	logic [POS_W-1:0] pos_q;
	logic [4:0] sec_q;
	logic [8:0] off_q;
	logic [5:0] chain_q;
	logic [5:0] acc_q;

	logic fmt;
	logic [8:0] g_full;
	logic [6:0] g;
	logic [8:0] u_full;
	logic [3:0] phys;
	logic [1:0] dsw;
	logic [5:0] prev;
	logic [8:0] rel;
	logic [7:0] fld;
	logic [7:0] sec_byte;
	logic [7:0] const_byte;
	logic [POS_W:0] pos_inc;

	function automatic logic [1:0] swap2(input logic [7:0] b);
		return {b[0], b[1]};
	endfunction

	assign fmt = ({1'b0, pos_q} < FMT_LIM);
	assign g_full = AUX_TOP - off_q;
	assign g = g_full[6:0];
	assign u_full = off_q - OFF_UPPER;
	assign phys = sector_order ? ORDER_PRO[sec_q[3:0]] : ORDER_DOS[sec_q[3:0]];
	assign dsw = swap2(rdata);
	assign prev = (off_q == OFF_DATA) ? 6'd0 : chain_q;
	assign sec_byte = {4'd0, sec_q[3:0]};
	assign pos_inc = {1'b0, pos_q} + (POS_W+1)'(1);

	// byte class for the dispatch step
	always_comb begin
		cls = CLS_CONST;
		if (fmt && off_q >= OFF_DATA && off_q < OFF_UPPER) begin
			cls = CLS_AUX;
		end else if (fmt && off_q >= OFF_UPPER && off_q < OFF_CSUM) begin
			cls = CLS_UP;
		end
	end

	// store read address
	assign re = ctrl.rd_en;
	always_comb begin
		case (ctrl.rd_sel)
			RD_A: raddr = {phys, 1'b0, g};
			RD_B: raddr = {phys, {1'b0, g} + AUX_STRIDE};
			RD_C: raddr = {phys, {1'b0, g} + AUX_STRIDE2};
			RD_U: raddr = {phys, u_full[7:0]};
			default: raddr = {phys, 8'd0};
		endcase
	end

	// accumulator collects one chain value
	always_ff @(posedge clk) begin
		case (ctrl.cap)
			CAP_LO: acc_q <= {4'd0, dsw};
			CAP_MID: acc_q[3:2] <= dsw;
			CAP_HI: acc_q[5:4] <= (g < AUX_FULL) ? dsw : 2'd0;
			CAP_UP: acc_q <= rdata[7:2];
			default: acc_q <= acc_q;
		endcase
	end

	// address field byte select, odd-even encoded
	always_comb begin
		rel = off_q - OFF_AFIELD;
		case (rel[2:1])
			2'd0: fld = VOLUME;
			2'd1: fld = trk_num;
			2'd2: fld = sec_byte;
			default: fld = VOLUME ^ trk_num ^ sec_byte;
		endcase
	end

	// framing, marks, sync, address field and checksum bytes
	always_comb begin
		const_byte = SYNC_BYTE;
		if (!fmt || off_q < OFF_AMARK) begin
			const_byte = SYNC_BYTE;
		end else if (off_q < OFF_AFIELD) begin
			const_byte = ADDR_MARK[2'(off_q - OFF_AMARK)];
		end else if (off_q < OFF_ATAIL) begin
			const_byte = rel[0] ? (fld | ODD_EVEN_MASK) : ((fld >> 1) | ODD_EVEN_MASK);
		end else if (off_q < OFF_GAP) begin
			const_byte = TAIL_MARK[2'(off_q - OFF_ATAIL)];
		end else if (off_q < OFF_DMARK) begin
			const_byte = SYNC_BYTE;
		end else if (off_q < OFF_DATA) begin
			const_byte = DATA_MARK[2'(off_q - OFF_DMARK)];
		end else if (off_q == OFF_CSUM) begin
			const_byte = DISK_CODE[chain_q];
		end else if (off_q >= OFF_DTAIL) begin
			const_byte = TAIL_MARK[2'(off_q - OFF_DTAIL)];
		end
	end

	assign byte_out = ctrl.emit_data ? DISK_CODE[acc_q ^ prev] : const_byte;
	assign last_out = (pos_inc >= TRACK_LIM);

	// position advances when an item goes out, chain value when a data item goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sec_q <= '0;
			off_q <= '0;
			chain_q <= '0;
		end else if (ctrl.emit) begin
			if (ctrl.emit_data) begin
				chain_q <= acc_q;
			end
			if (last_out) begin
				pos_q <= '0;
				sec_q <= '0;
				off_q <= '0;
			end else begin
				pos_q <= pos_inc[POS_W-1:0];
				if (off_q == OFF_END) begin
					off_q <= '0;
					sec_q <= sec_q + 5'd1;
				end else begin
					off_q <= off_q + 9'd1;
				end
			end
		end
	end

endmodule

// File: design/gcr_sector_track_formatter_unit.sv
// 6-and-2 gcr sector track formatter top level
// a load item is written straight to the store; following the microprogram, a pull item is
// dispatched, then emits a sync, mark or field byte directly, reads the store once for an
// upper data byte, or three times for an auxiliary group, through the single store port
// a pull result is held in the output register; the next item enters while it waits there
// reset clears position, chain, config registers, out_valid and step counter; not the store
module gcr_sector_track_formatter_unit
	import gcrf_pkg::*;
#(
	parameter int TRACK_SIZE = TRACK_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_item,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [7:0] cfg_data
);

	logic in_acc;
	logic pull;
	logic load;
	logic idle;
	logic out_busy;
	logic [1:0] cls;
	ctrl_t ctrl;
	logic re;
	logic [ADDR_W-1:0] raddr;
	logic [7:0] rdata;
	logic [7:0] byte_out;
	logic last_out;
	logic [7:0] track_q;
	logic order_q;
	logic out_valid_q;
	out_item_t out_item_q;

	assign in_ready = idle;
	assign in_acc = in_valid & in_ready;
	assign pull = in_acc & (in_item.opcode == OP_PULL);
	assign load = in_acc & (in_item.opcode == OP_LOAD);
	assign out_busy = out_valid_q & ~out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= '0;
			order_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRACK: track_q <= cfg_data;
				REG_ORDER: order_q <= cfg_data[0];
				default: track_q <= track_q;
			endcase
		end
	end

	gcrf_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.pull(pull),
		.cls(cls),
		.out_busy(out_busy),
		.ctrl(ctrl),
		.idle(idle)
	);

	gcrf_store u_store (
		.clk(clk),
		.we(load),
		.waddr(in_item.load_address),
		.wdata(in_item.load_byte),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	gcrf_dp #(
		.TRACK_SIZE(TRACK_SIZE)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.trk_num(track_q),
		.sector_order(order_q),
		.rdata(rdata),
		.re(re),
		.raddr(raddr),
		.cls(cls),
		.byte_out(byte_out),
		.last_out(last_out)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_item_q.track_byte <= byte_out;
			out_item_q.last_byte <= last_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule
